FILE: hdl/sosk_pkg.sv
// Shared types, constants and functions of the SOSEMANUK keystream engine.
// Holds the Serpent S-box tables, the GF(2^32) basis tables and the round helpers.
// Depends on nothing.
package sosk_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_IV_RD,
		ST_IV_RND,
		ST_IV_LD,
		ST_GEN,
		ST_DONE
	} sosk_state_t;

	typedef enum logic [1:0] {
		OP_KEY = 2'd0,
		OP_IV  = 2'd1,
		OP_GEN = 2'd2,
		OP_NOP = 2'd3
	} sosk_op_t;

	typedef enum logic [2:0] {
		REG_KEY_BITS = 3'd0,
		REG_KEY_A    = 3'd1,
		REG_KEY_B    = 3'd2,
		REG_KEY_C    = 3'd3,
		REG_KEY_D    = 3'd4
	} sosk_reg_t;

	localparam logic [31:0] GOLDEN   = 32'h9e3779b9;
	localparam logic [31:0] FSM_MULT = 32'h54655307;

	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
		  4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
		'{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
		  4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
		'{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
		  4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
		'{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
		  4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
		'{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
		  4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
		'{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
		  4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
		'{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
		  4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
		'{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
		  4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
	};

	localparam logic [31:0] MUL_BASIS [8] = '{
		32'hE19FCF13, 32'h6B973726, 32'hD6876E4C, 32'h05A7DC98,
		32'h0AE71199, 32'h1467229B, 32'h28CE449F, 32'h50358897
	};
	localparam logic [31:0] DIV_BASIS [8] = '{
		32'h180F40CD, 32'h301E8033, 32'h603CA966, 32'hC078FBCC,
		32'h29F05F31, 32'h5249BE62, 32'hA492D5C4, 32'hE18D0321
	};

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] mul_alpha(input logic [7:0] b);
		logic [31:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++)
			if (b[i]) acc = acc ^ MUL_BASIS[i];
		return acc;
	endfunction

	function automatic logic [31:0] div_alpha(input logic [7:0] b);
		logic [31:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++)
			if (b[i]) acc = acc ^ DIV_BASIS[i];
		return acc;
	endfunction

	// Bitsliced S-box: word j of the block sits at bits [32*j +: 32].
	function automatic logic [127:0] sbox_bitslice(input logic [2:0] idx, input logic [127:0] x);
		logic [127:0] r;
		logic [3:0] n;
		logic [3:0] v;
		r = '0;
		for (int k = 0; k < 32; k++) begin
			n = {x[96 + k], x[64 + k], x[32 + k], x[k]};
			v = SBOX[idx][n];
			r[k]      = v[0];
			r[32 + k] = v[1];
			r[64 + k] = v[2];
			r[96 + k] = v[3];
		end
		return r;
	endfunction

	function automatic logic [127:0] round_mix(input logic [2:0] idx,
			input logic [127:0] d, input logic [127:0] sk);
		logic [127:0] s;
		logic [31:0] a0, a1, a2, a3;
		s  = sbox_bitslice(idx, d ^ sk);
		a0 = rotl32(s[31:0], 13);
		a2 = rotl32(s[95:64], 3);
		a1 = s[63:32] ^ a0 ^ a2;
		a3 = s[127:96] ^ a2 ^ (a0 << 3);
		a1 = rotl32(a1, 1);
		a3 = rotl32(a3, 7);
		a0 = a0 ^ a1 ^ a3;
		a2 = a2 ^ a3 ^ (a1 << 7);
		a0 = rotl32(a0, 5);
		a2 = rotl32(a2, 22);
		return {a3, a2, a1, a0};
	endfunction

endpackage

FILE: hdl/sosemanuk_keystream_generator_top.sv
// SOSEMANUK keystream engine: key schedule, IV setup and keystream generation.
// Depends on sosk_pkg; keeps the subkeys in one synchronous 25 x 128 memory.
//
// Channel   Dir  Bits  Contents
// s_*       in   136   op, iv_low, iv_high (tdata)
// m_*       out  128   stream_low, stream_high (tdata)
// cfg_*     in   64    key_bits, key_word_a..d writes
//
// Op 0 runs the key schedule (one subkey word a cycle, one memory row per four words).
// Op 1 runs 24 rounds, each a row read then a round, plus a final add.
// Op 2 runs four FSM/LFSR steps, then loads the output register.
// Op 3 does nothing. No clearing pass after reset.
// A result held by a stalled master side blocks only the next keystream hand-off.
module sosemanuk_keystream_generator_top
	import sosk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // op[1:0], iv_low[65:2], iv_high[129:66], zero fill
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // stream_low[63:0], stream_high[127:64]
);

	sosk_state_t state_q, state_d;

	logic [8:0]   key_bits_q;
	logic [63:0]  key_q [4];

	// Subkey memory: row j holds subkeys 4j..4j+3, word 0 in the low bits.
	logic [127:0] sk_mem [25];
	logic [127:0] sk_rd_q;
	logic [4:0]   rnd_q;

	logic [31:0]  win_q [8];
	logic [31:0]  pad_win [8];
	logic [6:0]   key_cnt_q;
	logic [31:0]  key_w;
	logic [8:0]   key_len;

	logic [127:0] d_q;
	logic [127:0] d_next;

	// LFSR held in head-relative order: lfsr_q[0] is the oldest word.
	logic [31:0]  lfsr_q [10];
	logic [31:0]  fsm1_q, fsm2_q;
	logic [1:0]   gen_cnt_q;
	logic [127:0] f_q, drop_q;

	logic [31:0]  sel, fsm1_n, fsm2_n, f_n, lfsr_n, prod;

	logic         m_tvalid_q;
	logic [127:0] m_data_q;

	logic         in_xfer;
	sosk_op_t     in_op;

	assign in_op    = sosk_op_t'(s_tdata[1:0]);
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	// Pad the key: clear bits at and above the length, set one bit at the length.
	always_comb begin
		key_len = (key_bits_q > 9'd256) ? 9'd256 : key_bits_q;
		for (int i = 0; i < 8; i++) begin
			if (i < 32'(key_len[8:5]))
				pad_win[i] = key_q[i / 2][32 * (i % 2) +: 32];
			else if (i == 32'(key_len[8:5]))
				pad_win[i] = (key_q[i / 2][32 * (i % 2) +: 32] &
					((32'd1 << key_len[4:0]) - 32'd1)) | (32'd1 << key_len[4:0]);
			else
				pad_win[i] = '0;
		end
	end

	assign key_w  = rotl32(win_q[0] ^ win_q[3] ^ win_q[5] ^ win_q[7] ^ GOLDEN ^
		{25'd0, key_cnt_q}, 11);
	assign d_next = round_mix(rnd_q[2:0], d_q, sk_rd_q);

	// One FSM and LFSR step
	assign prod   = 32'(fsm1_q * FSM_MULT);
	assign sel    = fsm1_q[0] ? (lfsr_q[1] ^ lfsr_q[8]) : lfsr_q[1];
	assign fsm1_n = fsm2_q + sel;
	assign fsm2_n = rotl32(prod, 7);
	assign f_n    = (lfsr_q[9] + fsm1_n) ^ fsm2_n;
	assign lfsr_n = lfsr_q[9] ^ (lfsr_q[3] >> 8) ^ div_alpha(lfsr_q[3][7:0]) ^
		(lfsr_q[0] << 8) ^ mul_alpha(lfsr_q[0][31:24]);

	// Memory: write one row, read one row, read data registered.
	always_ff @(posedge clk) begin
		if (state_q == ST_KEY && key_cnt_q[1:0] == 2'd3)
			sk_mem[key_cnt_q[6:2]] <= sbox_bitslice(3'd3 - key_cnt_q[4:2],
				{key_w, win_q[7], win_q[6], win_q[5]});
		sk_rd_q <= sk_mem[rnd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bits_q <= 9'd128;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_BITS: key_bits_q <= cfg_data[8:0];
				REG_KEY_A:    key_q[0]   <= cfg_data;
				REG_KEY_B:    key_q[1]   <= cfg_data;
				REG_KEY_C:    key_q[2]   <= cfg_data;
				REG_KEY_D:    key_q[3]   <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (in_op)
						OP_KEY:  state_d = ST_KEY;
						OP_IV:   state_d = ST_IV_RD;
						OP_GEN:  state_d = ST_GEN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_KEY:    if (key_cnt_q == 7'd99) state_d = ST_IDLE;
			ST_IV_RD:  state_d = (rnd_q == 5'd24) ? ST_IV_LD : ST_IV_RND;
			ST_IV_RND: state_d = ST_IV_RD;
			ST_IV_LD:  state_d = ST_IDLE;
			ST_GEN:    if (gen_cnt_q == 2'd3) state_d = ST_DONE;
			ST_DONE:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control counters and the reset-zero cipher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cnt_q  <= '0;
			rnd_q      <= '0;
			gen_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			fsm1_q     <= '0;
			fsm2_q     <= '0;
			for (int i = 0; i < 10; i++) lfsr_q[i] <= '0;
		end else begin
			// Raise valid on a finished block, drop it after its transfer.
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					key_cnt_q <= '0;
					rnd_q     <= '0;
					gen_cnt_q <= '0;
				end
				ST_KEY: key_cnt_q <= key_cnt_q + 7'd1;
				ST_IV_RND: begin
					rnd_q <= rnd_q + 5'd1;
					if (rnd_q == 5'd11) begin
						lfsr_q[9] <= d_next[31:0];
						lfsr_q[8] <= d_next[63:32];
						lfsr_q[7] <= d_next[95:64];
						lfsr_q[6] <= d_next[127:96];
					end
					if (rnd_q == 5'd17) begin
						fsm1_q    <= d_next[31:0];
						fsm2_q    <= d_next[95:64];
						lfsr_q[5] <= d_next[127:96];
						lfsr_q[4] <= d_next[63:32];
					end
				end
				ST_IV_LD: begin
					lfsr_q[3] <= d_q[31:0]   ^ sk_rd_q[31:0];
					lfsr_q[2] <= d_q[63:32]  ^ sk_rd_q[63:32];
					lfsr_q[1] <= d_q[95:64]  ^ sk_rd_q[95:64];
					lfsr_q[0] <= d_q[127:96] ^ sk_rd_q[127:96];
				end
				ST_GEN: begin
					gen_cnt_q <= gen_cnt_q + 2'd1;
					fsm1_q    <= fsm1_n;
					fsm2_q    <= fsm2_n;
					for (int i = 0; i < 9; i++) lfsr_q[i] <= lfsr_q[i + 1];
					lfsr_q[9] <= lfsr_n;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					d_q <= s_tdata[129:2];
					for (int i = 0; i < 8; i++) win_q[i] <= pad_win[i];
				end
			end
			ST_KEY: begin
				for (int i = 0; i < 7; i++) win_q[i] <= win_q[i + 1];
				win_q[7] <= key_w;
			end
			ST_IV_RND: d_q <= d_next;
			ST_GEN: begin
				f_q[32 * gen_cnt_q +: 32]    <= f_n;
				drop_q[32 * gen_cnt_q +: 32] <= lfsr_q[0];
			end
			ST_DONE: if (!m_tvalid_q || m_tready) m_data_q <= sbox_bitslice(3'd2, f_q) ^ drop_q;
			default: ;
		endcase
	end

	a_gen_exits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN |=> state_q == ST_GEN || state_q == ST_DONE)
		else $error("keystream steps left early");

	a_rose_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished block");

	a_iv_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && in_op == OP_IV |=> state_q == ST_IV_RD && rnd_q == 5'd0)
		else $error("IV setup did not start at round zero");

	a_key_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_KEY |-> key_cnt_q < 7'd100)
		else $error("key schedule ran past 100 words");

endmodule
